[design/dlpl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlpl_pkg: shared types and constants of the DAG longest-path leveler
// Sizes of the edge store and node cells, the queue word, the cell control
// bundle and the back-end sequencer states.
// ----------------------------------------------------------------------------
package dlpl_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 256;

	// Node cells in use: node indexes are six bits wide.
	localparam int NODE_CAP = (MAX_NODES < 64) ? MAX_NODES : 64;

	localparam int NODE_W  = 6;
	localparam int CNT_W   = 7;
	localparam int LEVEL_W = 6;
	localparam int EDGE_AW = $clog2(MAX_EDGES);
	localparam int ECNT_W  = EDGE_AW + 1;
	localparam int DEG_W   = ECNT_W;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CNT_W-1:0]   count_t;

	// One accepted edge after classification.
	typedef struct packed {
		logic  valid_edge;
		logic  last;
		node_t from_node;
		node_t to_node;
	} edge_item_t;

	// Commands from the sequencer to the node cells.
	typedef struct packed {
		logic               clear;
		logic               inc;
		logic               dec;
		logic               mark;
		logic               shift;
		node_t              node;
		logic [LEVEL_W:0]   lv_inc;
	} cell_ctrl_t;

	// Status from the node cells back to the sequencer.
	typedef struct packed {
		logic   hit;
		level_t hit_level;
		level_t head_level;
		logic   head_mark;
	} cell_stat_t;

	// Edge-sweep pipeline stage.
	typedef struct packed {
		logic valid;
		logic deg;
	} scan_stage_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DEG,
		ST_DEG_DRAIN,
		ST_SNAP,
		ST_SRC,
		ST_POP,
		ST_FETCH,
		ST_SCAN,
		ST_SCAN_DRAIN,
		ST_EMIT,
		ST_CLEAR
	} back_state_t;

endpackage
`default_nettype wire

[design/dlpl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlpl_front: input side of the leveler
// Accepts edge words and marks each as a stored edge or an ignored one.
// ----------------------------------------------------------------------------
module dlpl_front (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dlpl_pkg::S_TDATA_W-1:0] s_tdata,   // [5:0] from_node, [11:6] to_node
	input  wire logic                           s_tuser,   // [0] skip_edge
	input  wire logic                           s_tlast,
	input  wire dlpl_pkg::count_t               count,
	input  wire logic                           q_full,
	output logic                                q_push,
	output dlpl_pkg::edge_item_t                q_item
);

	dlpl_pkg::node_t from_w;
	dlpl_pkg::node_t to_w;

	assign from_w = s_tdata[dlpl_pkg::NODE_W-1:0];
	assign to_w   = s_tdata[2*dlpl_pkg::NODE_W-1:dlpl_pkg::NODE_W];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// An edge is kept only if not skipped and both ends are in range.
	always_comb begin
		q_item.from_node  = from_w;
		q_item.to_node    = to_w;
		q_item.last       = s_tlast;
		q_item.valid_edge = !s_tuser
			&& ({1'b0, from_w} < count) && ({1'b0, to_w} < count);
	end

endmodule
`default_nettype wire

[design/dlpl_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlpl_queue: short queue between front and back
// Holds a few classified edges so either side can stall on its own.
// ----------------------------------------------------------------------------
module dlpl_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire dlpl_pkg::edge_item_t push_item,
	output logic                      full,
	output logic                      pop_valid,
	input  wire logic                 pop_ready,
	output dlpl_pkg::edge_item_t      pop_item
);

	dlpl_pkg::edge_item_t entry_q [dlpl_pkg::QDEPTH];
	logic [dlpl_pkg::QAW-1:0] wr_q;
	logic [dlpl_pkg::QAW-1:0] rd_q;
	logic [dlpl_pkg::QAW:0]   fill_q;
	logic                     pop;

	assign full      = (fill_q == (dlpl_pkg::QAW+1)'(dlpl_pkg::QDEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_item  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[design/dlpl_cells.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlpl_cells: per-node state cells
// Each cell holds one node's in-degree, level and dequeued mark and updates
// itself when the broadcast node index selects it. Results leave by shifting.
// ----------------------------------------------------------------------------
module dlpl_cells (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dlpl_pkg::cell_ctrl_t         ctrl,
	output dlpl_pkg::cell_stat_t              stat,
	output logic [dlpl_pkg::NODE_CAP-1:0]     zero_vec
);

	logic [dlpl_pkg::DEG_W-1:0]                      indeg_q [dlpl_pkg::NODE_CAP];
	logic [dlpl_pkg::NODE_CAP-1:0][dlpl_pkg::LEVEL_W-1:0] level_q;
	logic [dlpl_pkg::NODE_CAP-1:0]                   deq_q;
	logic [dlpl_pkg::NODE_CAP-1:0]                   sel;
	logic [dlpl_pkg::NODE_CAP-1:0]                   raise;

	always_comb begin
		for (int i = 0; i < dlpl_pkg::NODE_CAP; i++) begin
			sel[i]      = (ctrl.node == dlpl_pkg::NODE_W'(i));
			raise[i]    = (ctrl.lv_inc > {1'b0, level_q[i]});
			zero_vec[i] = (indeg_q[i] == '0);
		end
	end

	// The cell whose last incoming edge is being removed reports its new level.
	always_comb begin
		stat.hit        = 1'b0;
		stat.hit_level  = '0;
		stat.head_level = level_q[0];
		stat.head_mark  = deq_q[0];
		for (int i = 0; i < dlpl_pkg::NODE_CAP; i++) begin
			if (ctrl.dec && sel[i] && (indeg_q[i] == dlpl_pkg::DEG_W'(1))) begin
				stat.hit       = 1'b1;
				stat.hit_level = stat.hit_level
					| (raise[i] ? ctrl.lv_inc[dlpl_pkg::LEVEL_W-1:0] : level_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dlpl_pkg::NODE_CAP; i++) begin
				indeg_q[i] <= '0;
			end
			level_q <= '0;
			deq_q   <= '0;
		end else if (ctrl.clear) begin
			for (int i = 0; i < dlpl_pkg::NODE_CAP; i++) begin
				indeg_q[i] <= '0;
			end
			level_q <= '0;
			deq_q   <= '0;
		end else if (ctrl.shift) begin
			level_q <= {{dlpl_pkg::LEVEL_W{1'b0}}, level_q[dlpl_pkg::NODE_CAP-1:1]};
			deq_q   <= deq_q >> 1;
		end else begin
			for (int i = 0; i < dlpl_pkg::NODE_CAP; i++) begin
				if (ctrl.inc && sel[i]) begin
					indeg_q[i] <= indeg_q[i] + 1'b1;
				end
				if (ctrl.dec && sel[i]) begin
					if (raise[i]) begin
						level_q[i] <= ctrl.lv_inc[dlpl_pkg::LEVEL_W-1:0];
					end
					if (indeg_q[i] != '0) begin
						indeg_q[i] <= indeg_q[i] - 1'b1;
					end
				end
				if (ctrl.mark && sel[i]) begin
					deq_q[i] <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

[design/dlpl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dlpl_back: edge store and topological-walk sequencer
// Stores edges, counts in-degrees, queues source nodes, runs the ready-queue
// walk with one edge sweep per dequeued node and shifts the results out.
// ----------------------------------------------------------------------------
module dlpl_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dlpl_pkg::count_t               count,
	input  wire logic                           q_valid,
	output logic                                q_ready,
	input  wire dlpl_pkg::edge_item_t           q_item,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [dlpl_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [dlpl_pkg::M_TUSER_W-1:0]      m_tuser,
	output logic                                m_tlast
);

	localparam int EW = 2 * dlpl_pkg::NODE_W;
	localparam int RW = dlpl_pkg::NODE_W + dlpl_pkg::LEVEL_W;

	dlpl_pkg::back_state_t state_q, state_d;

	// Edge store and its sweep pipeline.
	logic [EW-1:0]                  emem [dlpl_pkg::MAX_EDGES];
	logic [EW-1:0]                  erd_s1;
	dlpl_pkg::scan_stage_t          stg_s1;
	logic [dlpl_pkg::ECNT_W-1:0]    ecnt_q;
	logic [dlpl_pkg::ECNT_W-1:0]    eidx_q;
	logic                           ovf_q;

	// Ready queue of {node, level}.
	logic [RW-1:0]                  rmem [dlpl_pkg::NODE_CAP];
	logic [RW-1:0]                  rrd_q;
	dlpl_pkg::count_t               rhead_q;
	dlpl_pkg::count_t               rtail_q;

	dlpl_pkg::node_t                cur_q;
	logic [dlpl_pkg::LEVEL_W:0]     lvp1_q;
	logic [dlpl_pkg::NODE_CAP-1:0]  zv_q;
	dlpl_pkg::count_t               sidx_q;
	dlpl_pkg::count_t               n_q;

	logic                           out_valid_q;
	dlpl_pkg::node_t                out_index_q;
	dlpl_pkg::level_t               out_level_q;
	logic                           out_never_q;
	logic                           out_drop_q;
	logic                           out_last_q;

	dlpl_pkg::cell_ctrl_t           cc;
	dlpl_pkg::cell_stat_t           cs;
	logic [dlpl_pkg::NODE_CAP-1:0]  zero_vec;
	logic [dlpl_pkg::NODE_CAP-1:0]  live_vec;

	dlpl_pkg::node_t                proc_src;
	dlpl_pkg::node_t                proc_dst;
	logic                           proc_src_ok;
	logic                           proc_dst_ok;
	logic                           e_full;
	logic                           e_wr;
	logic                           e_last_idx;
	logic                           q_take;
	logic                           src_push;
	logic                           r_push;
	logic [RW-1:0]                  r_push_word;
	logic                           r_pop;
	logic                           emit_load;
	logic                           emit_slot;

	dlpl_cells u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (cc),
		.stat     (cs),
		.zero_vec (zero_vec)
	);

	assign proc_src    = erd_s1[EW-1:dlpl_pkg::NODE_W];
	assign proc_dst    = erd_s1[dlpl_pkg::NODE_W-1:0];
	assign proc_src_ok = ({1'b0, proc_src} < count);
	assign proc_dst_ok = ({1'b0, proc_dst} < count);

	assign e_full     = (ecnt_q == dlpl_pkg::ECNT_W'(dlpl_pkg::MAX_EDGES));
	assign e_last_idx = (eidx_q == ecnt_q - 1'b1);
	assign q_ready    = (state_q == dlpl_pkg::ST_LOAD);
	assign q_take     = q_valid && q_ready;
	assign e_wr       = q_take && q_item.valid_edge && !e_full;
	assign emit_slot  = !out_valid_q || m_tready;

	always_comb begin
		for (int i = 0; i < dlpl_pkg::NODE_CAP; i++) begin
			live_vec[i] = zero_vec[i] && (dlpl_pkg::CNT_W'(i) < count);
		end
	end

	// Cell commands: sweep results act on the target node, a fetch marks
	// the dequeued node.
	always_comb begin
		cc.clear  = (state_q == dlpl_pkg::ST_CLEAR);
		cc.inc    = stg_s1.valid && stg_s1.deg && proc_src_ok && proc_dst_ok;
		cc.dec    = stg_s1.valid && !stg_s1.deg && (proc_src == cur_q) && proc_dst_ok;
		cc.mark   = (state_q == dlpl_pkg::ST_FETCH);
		cc.shift  = emit_load;
		cc.node   = cc.mark ? rrd_q[RW-1:dlpl_pkg::LEVEL_W] : proc_dst;
		cc.lv_inc = lvp1_q;
	end

	assign src_push    = (state_q == dlpl_pkg::ST_SRC) && zv_q[0];
	assign r_push      = (src_push || cs.hit) && (rtail_q < dlpl_pkg::CNT_W'(dlpl_pkg::NODE_CAP));
	assign r_push_word = src_push ? {sidx_q[dlpl_pkg::NODE_W-1:0], {dlpl_pkg::LEVEL_W{1'b0}}}
	                              : {proc_dst, cs.hit_level};

	always_comb begin
		state_d   = state_q;
		r_pop     = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			dlpl_pkg::ST_LOAD: begin
				if (q_take && q_item.last) begin
					if ((ecnt_q != '0) || q_item.valid_edge) begin
						state_d = dlpl_pkg::ST_DEG;
					end else begin
						state_d = dlpl_pkg::ST_SNAP;
					end
				end
			end
			dlpl_pkg::ST_DEG: begin
				if (e_last_idx) begin
					state_d = dlpl_pkg::ST_DEG_DRAIN;
				end
			end
			dlpl_pkg::ST_DEG_DRAIN: begin
				state_d = dlpl_pkg::ST_SNAP;
			end
			dlpl_pkg::ST_SNAP: begin
				state_d = (count == '0) ? dlpl_pkg::ST_POP : dlpl_pkg::ST_SRC;
			end
			dlpl_pkg::ST_SRC: begin
				if (sidx_q == count - 1'b1) begin
					state_d = dlpl_pkg::ST_POP;
				end
			end
			dlpl_pkg::ST_POP: begin
				if (rhead_q < rtail_q) begin
					r_pop   = 1'b1;
					state_d = dlpl_pkg::ST_FETCH;
				end else begin
					state_d = dlpl_pkg::ST_EMIT;
				end
			end
			dlpl_pkg::ST_FETCH: begin
				state_d = (ecnt_q == '0) ? dlpl_pkg::ST_POP : dlpl_pkg::ST_SCAN;
			end
			dlpl_pkg::ST_SCAN: begin
				if (e_last_idx) begin
					state_d = dlpl_pkg::ST_SCAN_DRAIN;
				end
			end
			dlpl_pkg::ST_SCAN_DRAIN: begin
				state_d = dlpl_pkg::ST_POP;
			end
			dlpl_pkg::ST_EMIT: begin
				if (count == '0) begin
					state_d = dlpl_pkg::ST_CLEAR;
				end else if (emit_slot) begin
					emit_load = 1'b1;
					if (n_q == count - 1'b1) begin
						state_d = dlpl_pkg::ST_CLEAR;
					end
				end
			end
			dlpl_pkg::ST_CLEAR: begin
				state_d = dlpl_pkg::ST_LOAD;
			end
			default: begin
				state_d = dlpl_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlpl_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (e_wr) begin
			emem[ecnt_q[dlpl_pkg::EDGE_AW-1:0]] <= {q_item.from_node, q_item.to_node};
		end
		erd_s1 <= emem[eidx_q[dlpl_pkg::EDGE_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (r_push) begin
			rmem[rtail_q[dlpl_pkg::NODE_W-1:0]] <= r_push_word;
		end
		if (r_pop) begin
			rrd_q <= rmem[rhead_q[dlpl_pkg::NODE_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dlpl_pkg::ST_FETCH) begin
			cur_q  <= rrd_q[RW-1:dlpl_pkg::LEVEL_W];
			lvp1_q <= {1'b0, rrd_q[dlpl_pkg::LEVEL_W-1:0]} + 1'b1;
		end
		if (state_q == dlpl_pkg::ST_SNAP) begin
			zv_q <= live_vec;
		end else if (state_q == dlpl_pkg::ST_SRC) begin
			zv_q <= zv_q >> 1;
		end
		if (emit_load) begin
			out_index_q <= n_q[dlpl_pkg::NODE_W-1:0];
			out_level_q <= cs.head_level;
			out_never_q <= !cs.head_mark;
			out_drop_q  <= ovf_q;
			out_last_q  <= (n_q == count - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s1      <= '0;
			ecnt_q      <= '0;
			eidx_q      <= '0;
			ovf_q       <= 1'b0;
			rhead_q     <= '0;
			rtail_q     <= '0;
			sidx_q      <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			stg_s1.valid <= (state_q == dlpl_pkg::ST_DEG) || (state_q == dlpl_pkg::ST_SCAN);
			stg_s1.deg   <= (state_q == dlpl_pkg::ST_DEG);

			if (e_wr) begin
				ecnt_q <= ecnt_q + 1'b1;
			end
			if (q_take && q_item.valid_edge && e_full) begin
				ovf_q <= 1'b1;
			end

			if ((state_q == dlpl_pkg::ST_DEG) || (state_q == dlpl_pkg::ST_SCAN)) begin
				eidx_q <= eidx_q + 1'b1;
			end else begin
				eidx_q <= '0;
			end

			if (r_push) begin
				rtail_q <= rtail_q + 1'b1;
			end
			if (r_pop) begin
				rhead_q <= rhead_q + 1'b1;
			end

			if (state_q == dlpl_pkg::ST_SRC) begin
				sidx_q <= sidx_q + 1'b1;
			end else begin
				sidx_q <= '0;
			end

			if (emit_load) begin
				n_q <= n_q + 1'b1;
			end else if (state_q != dlpl_pkg::ST_EMIT) begin
				n_q <= '0;
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == dlpl_pkg::ST_CLEAR) begin
				ecnt_q  <= '0;
				ovf_q   <= 1'b0;
				rhead_q <= '0;
				rtail_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dlpl_pkg::M_TDATA_W'({out_level_q, out_index_q});
	assign m_tuser  = {out_drop_q, out_never_q};
	assign m_tlast  = out_last_q;

	// The ready queue never holds more entries than there are nodes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rhead_q <= rtail_q) && (rtail_q <= dlpl_pkg::CNT_W'(dlpl_pkg::NODE_CAP)))
		else $error("ready queue pointers out of order");

	// The edge store count stays within its capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= dlpl_pkg::ECNT_W'(dlpl_pkg::MAX_EDGES))
		else $error("edge count beyond store size");

	// No sweep work is in flight while new edges are being loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlpl_pkg::ST_LOAD) |-> !stg_s1.valid)
		else $error("edge sweep active during load");

	// A node becomes ready only as a result of a walk sweep, never with a source push.
	assert property (@(posedge clk) disable iff (!arst_n)
		cs.hit |-> (stg_s1.valid && !stg_s1.deg && !src_push))
		else $error("ready push outside a walk sweep");

endmodule
`default_nettype wire

[design/dag_longest_path_leveler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dag_longest_path_leveler_core: longest-path layering of a directed graph
// Loads edges, runs a topological walk after the last one and reports a level
// and a cycle flag for every node in index order.
// ----------------------------------------------------------------------------
// Loading: one edge word is taken per cycle while loading. After the last word
//   every dequeued node sweeps the whole edge store through its single read port.
// Throughput: one run at a time; during a run the front end still takes up
//   to four words of the next graph into its queue, and the back end starts
//   storing them after the clear state that follows the last node word.
// Reset: arst_n clears all control state and the node cells at once; the
//   edge store needs no clearing pass, so the block is ready right away.
// ----------------------------------------------------------------------------
module dag_longest_path_leveler_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	// Edge words in.
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dlpl_pkg::S_TDATA_W-1:0] s_tdata,   // [5:0] from_node, [11:6] to_node
	input  wire logic                           s_tuser,   // [0] skip_edge
	input  wire logic                           s_tlast,   // last_edge

	// Node result words out.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [dlpl_pkg::M_TDATA_W-1:0]      m_tdata,   // [5:0] node_index, [11:6] node_level
	output logic [dlpl_pkg::M_TUSER_W-1:0]      m_tuser,   // [0] never_dequeued, [1] edges_dropped
	output logic                                m_tlast,   // last_node

	// Node count register write.
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dlpl_pkg::CNT_W-1:0]     cfg_data
);

	// The node count is held already limited to the number of node cells.
	dlpl_pkg::count_t      count_q;

	logic                  q_push;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_ready;
	dlpl_pkg::edge_item_t  q_in;
	dlpl_pkg::edge_item_t  q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= dlpl_pkg::CNT_W'(dlpl_pkg::NODE_CAP);
		end else if (cfg_valid) begin
			if (cfg_data > dlpl_pkg::CNT_W'(dlpl_pkg::NODE_CAP)) begin
				count_q <= dlpl_pkg::CNT_W'(dlpl_pkg::NODE_CAP);
			end else begin
				count_q <= cfg_data;
			end
		end
	end

	// Front end: takes edge words and decides whether each edge is kept.
	dlpl_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.count    (count_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	// A few words of slack, so input stalls and walk time are decoupled.
	dlpl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_item  (q_out)
	);

	// Back end: edge store, walk sequencer, node cells and output register.
	dlpl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.count    (count_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_out),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

[bench/tb_dag_longest_path_leveler_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dag_longest_path_leveler_core: self-checking bench for the graph leveler
// Streams edge words into the core and keeps its own model of the edge store
// and the topological walk. Each node word that comes back is checked against
// the oldest predicted one. Directed graphs cover the corner cases. Random
// graphs follow, with changes to the node count and with idling on both sides.
// ----------------------------------------------------------------------------
module tb_dag_longest_path_leveler_core;

	localparam int WORDS_WANTED  = 480;
	localparam int SETTLE_CYCLES = 32;      // lets a run with no node words finish
	localparam int DRAIN_CYCLES  = 100;
	localparam int STALL_LIMIT   = 100000;  // outlasts the walk of a full edge store
	localparam int MAX_REPORTS   = 10;

	// One edge word as the sender sees it.
	typedef struct packed {
		dlpl_pkg::node_t from_node;
		dlpl_pkg::node_t to_node;
		logic            skip;
		logic            last;
	} edge_word_t;

	// One node word as the receiver sees it.
	typedef struct packed {
		dlpl_pkg::node_t  index;
		dlpl_pkg::level_t level;
		logic             never_dequeued;
		logic             dropped;
		logic             last;
	} node_word_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [dlpl_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic                           s_tuser   = 1'b0;
	logic                           s_tlast   = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [dlpl_pkg::M_TDATA_W-1:0] m_tdata;
	logic [dlpl_pkg::M_TUSER_W-1:0] m_tuser;
	logic                           m_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [dlpl_pkg::CNT_W-1:0]     cfg_data  = '0;

	// Model state: the node count in force, the edges kept so far in this
	// graph and whether the store has overflowed.
	dlpl_pkg::count_t count_setting    = dlpl_pkg::count_t'(64);
	dlpl_pkg::node_t  kept_from[$];
	dlpl_pkg::node_t  kept_to[$];
	logic             store_overflowed = 1'b0;

	node_word_t node_results_due[$];
	edge_word_t edge_words_pending[$];
	edge_word_t word_on_bus;

	int send_idle_pct = 21;
	int recv_idle_pct = 68;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	dag_longest_path_leveler_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Model of the core
	// ------------------------------------------------------------------------

	// Node count in use: the register value, capped at the number of cells.
	function automatic int live_nodes();
		return (int'(count_setting) > dlpl_pkg::NODE_CAP) ? dlpl_pkg::NODE_CAP
			: int'(count_setting);
	endfunction

	// Kahn's walk over the kept edges. Every node starts at level 0, each edge
	// out of a dequeued node lifts its target to one above the source. Nodes
	// whose in-degree never drops to zero sit in or behind a cycle. One node
	// word per node is predicted, then the graph state is cleared.
	function automatic void level_graph();
		int         nodes = live_nodes();
		int         in_deg[dlpl_pkg::NODE_CAP];
		int         depth[dlpl_pkg::NODE_CAP];
		bit         dequeued[dlpl_pkg::NODE_CAP];
		int         ready[$];
		int         cur;
		int         tgt;
		node_word_t w;
		foreach (in_deg[n]) begin
			in_deg[n]   = 0;
			depth[n]    = 0;
			dequeued[n] = 1'b0;
		end
		// The count may have dropped since an edge was kept, so check again.
		foreach (kept_from[e]) begin
			if (int'(kept_from[e]) < nodes && int'(kept_to[e]) < nodes)
				in_deg[kept_to[e]]++;
		end
		for (int n = 0; n < nodes; n++) begin
			if (in_deg[n] == 0)
				ready.push_back(n);
		end
		while (ready.size() > 0) begin
			cur = ready.pop_front();
			dequeued[cur] = 1'b1;
			foreach (kept_from[e]) begin
				tgt = int'(kept_to[e]);
				if (int'(kept_from[e]) == cur && tgt < nodes) begin
					if (depth[tgt] < depth[cur] + 1)
						depth[tgt] = depth[cur] + 1;
					if (in_deg[tgt] > 0) begin
						in_deg[tgt]--;
						if (in_deg[tgt] == 0)
							ready.push_back(tgt);
					end
				end
			end
		end
		for (int n = 0; n < nodes; n++) begin
			w.index          = dlpl_pkg::node_t'(n);
			w.level          = dlpl_pkg::level_t'(depth[n]);
			w.never_dequeued = !dequeued[n];
			w.dropped        = store_overflowed;
			w.last           = (n == nodes - 1);
			node_results_due.push_back(w);
		end
		kept_from.delete();
		kept_to.delete();
		store_overflowed = 1'b0;
	endfunction

	// An accepted edge word: keep the edge if it is in range and there is
	// room, and level the graph when it is the last one.
	function automatic void absorb_edge(input edge_word_t w);
		int nodes = live_nodes();
		if (!w.skip && int'(w.from_node) < nodes && int'(w.to_node) < nodes) begin
			if (kept_from.size() < dlpl_pkg::MAX_EDGES) begin
				kept_from.push_back(w.from_node);
				kept_to.push_back(w.to_node);
			end else begin
				store_overflowed = 1'b1;
			end
		end
		if (w.last)
			level_graph();
	endfunction

	function automatic void note_mismatch(input string what, input node_word_t want,
			input node_word_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected node %0d level %0d never %0b dropped %0b last %0b,",
				$realtime, what, want.index, want.level, want.never_dequeued,
				want.dropped, want.last,
				" got node %0d level %0d never %0b dropped %0b last %0b",
				got.index, got.level, got.never_dequeued, got.dropped, got.last);
	endfunction

	// ------------------------------------------------------------------------
	// Edge driver: takes words from the pending queue and holds each one on
	// the bus until it is accepted. The model is updated at acceptance.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				absorb_edge(word_on_bus);
			if (!s_tvalid || s_tready) begin
				if (edge_words_pending.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					word_on_bus = edge_words_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(dlpl_pkg::S_TDATA_W - 2 * dlpl_pkg::NODE_W){1'b0}},
						word_on_bus.to_node, word_on_bus.from_node};
					s_tuser  <= word_on_bus.skip;
					s_tlast  <= word_on_bus.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Node word monitor: stalls at random and checks every accepted word
	// against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		node_word_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.index          = m_tdata[dlpl_pkg::NODE_W-1:0];
				got.level          = m_tdata[dlpl_pkg::NODE_W +: dlpl_pkg::LEVEL_W];
				got.never_dequeued = m_tuser[0];
				got.dropped        = m_tuser[1];
				got.last           = m_tlast;
				if (node_results_due.size() == 0)
					note_mismatch("node word with none due", '0, got);
				else if (got !== node_results_due[0])
					note_mismatch("node word mismatch", node_results_due.pop_front(), got);
				else
					void'(node_results_due.pop_front());
			end
			m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// Watchdog: counts cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers. They run off the falling edge so that queue updates
	// never share a time step with the driver.
	// ------------------------------------------------------------------------
	task automatic queue_word(input int from_n, input int to_n, input bit skip, input bit last);
		edge_word_t w;
		w.from_node = dlpl_pkg::node_t'(from_n);
		w.to_node   = dlpl_pkg::node_t'(to_n);
		w.skip      = skip;
		w.last      = last;
		edge_words_pending.push_back(w);
	endtask

	// Hold off the stimulus until every word is accepted and every predicted
	// node word has come back.
	task automatic wait_quiet();
		@(negedge clk);
		while (edge_words_pending.size() != 0 || s_tvalid || node_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_count(input dlpl_pkg::count_t value);
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		count_setting = value;
		@(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	function automatic dlpl_pkg::count_t pick_count();
		case ($urandom_range(6, 0))
			0: return dlpl_pkg::count_t'(1);
			1: return dlpl_pkg::count_t'(2);
			2: return dlpl_pkg::count_t'(64);
			3: return dlpl_pkg::count_t'(127);
			4: return dlpl_pkg::count_t'($urandom_range(127, 65));
			5: return dlpl_pkg::count_t'(0);
			default: return dlpl_pkg::count_t'($urandom_range(64, 3));
		endcase
	endfunction

	// A random graph of n_edges words under the current node count. Noise
	// words are skipped or reach past the count. With two nodes or more and no
	// cyclic flag every kept edge points to a higher index, so the graph is acyclic.
	task automatic queue_graph(input int n_edges, input int noise_pct, input bit cyclic);
		int nodes = live_nodes();
		int a;
		int b;
		bit skip;
		for (int i = 0; i < n_edges; i++) begin
			skip = 1'b0;
			if (nodes == 0 || $urandom_range(99, 0) < noise_pct) begin
				a = $urandom_range(63, 0);
				b = $urandom_range(63, 0);
				if (nodes < dlpl_pkg::NODE_CAP && $urandom_range(1, 0)) begin
					if ($urandom_range(1, 0))
						a = $urandom_range(63, nodes);
					else
						b = $urandom_range(63, nodes);
				end else begin
					skip = 1'b1;
				end
			end else if (cyclic || nodes < 2) begin
				a = $urandom_range(nodes - 1, 0);
				b = $urandom_range(nodes - 1, 0);
			end else begin
				a = $urandom_range(nodes - 2, 0);
				b = $urandom_range(nodes - 1, a + 1);
			end
			queue_word(a, b, skip, i == n_edges - 1);
		end
	endtask

	// The longest possible path, 0 -> 1 -> ... -> 63, sent in shuffled order.
	task automatic queue_chain();
		int order[dlpl_pkg::NODE_CAP-1];
		int j;
		int t;
		foreach (order[i])
			order[i] = i;
		for (int i = dlpl_pkg::NODE_CAP - 2; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i])
			queue_word(order[i], order[i] + 1, 1'b0, i == dlpl_pkg::NODE_CAP - 2);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int graph_words;
		int n_words;
		int roll;
		bit chain_done;
		bit overflow_done;
		graph_words   = 0;
		chain_done    = 1'b0;
		overflow_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Node count from reset (64). A short path through both end indexes,
		// a self-loop, a two-node cycle with a node behind it, and a skipped
		// word.
		queue_word(0, 1, 1'b0, 1'b0);
		queue_word(1, 63, 1'b0, 1'b0);
		queue_word(63, 62, 1'b0, 1'b0);
		queue_word(2, 2, 1'b0, 1'b0);
		queue_word(3, 4, 1'b0, 1'b0);
		queue_word(4, 3, 1'b0, 1'b0);
		queue_word(3, 5, 1'b0, 1'b0);
		queue_word(10, 11, 1'b1, 1'b0);
		queue_word(62, 61, 1'b0, 1'b1);

		// A single node: edges past it are ignored, and a skipped word can
		// still close the graph.
		write_count(dlpl_pkg::count_t'(1));
		queue_word(0, 1, 1'b0, 1'b0);
		queue_word(63, 0, 1'b0, 1'b0);
		queue_word(0, 0, 1'b1, 1'b1);

		// No nodes at all: everything is ignored and nothing comes back.
		write_count(dlpl_pkg::count_t'(0));
		queue_word(0, 0, 1'b0, 1'b0);
		queue_word(5, 9, 1'b0, 1'b1);

		// A count above the cell limit saturates. The count then shrinks
		// while the graph is loading, which retires the edges into and out of node 40.
		write_count(dlpl_pkg::count_t'(127));
		queue_word(0, 1, 1'b0, 1'b0);
		queue_word(1, 2, 1'b0, 1'b0);
		queue_word(40, 41, 1'b0, 1'b0);
		queue_word(9, 40, 1'b0, 1'b0);
		write_count(dlpl_pkg::count_t'(10));
		queue_word(2, 3, 1'b0, 1'b1);
		write_count(dlpl_pkg::count_t'(64));

		// Random graphs: mostly acyclic with a little noise, some with
		// cycles, some dominated by noise. The longest chain is sent once
		// and the edge store is overrun once.
		while (graph_words < WORDS_WANTED) begin
			if (graph_words >= 200)
				set_idling(0, 0);
			else if (graph_words >= 120)
				set_idling(68, 21);
			if (!chain_done && graph_words >= 40) begin
				write_count(dlpl_pkg::count_t'(64));
				queue_chain();
				chain_done = 1'b1;
				graph_words += dlpl_pkg::NODE_CAP - 1;
			end else if (!overflow_done && graph_words >= 200) begin
				write_count(dlpl_pkg::count_t'(64));
				queue_graph(dlpl_pkg::MAX_EDGES + 8, 0, 1'b0);
				overflow_done = 1'b1;
				graph_words += dlpl_pkg::MAX_EDGES + 8;
			end else begin
				case ($urandom_range(7, 0))
					0, 1: write_count(pick_count());
					2: wait_quiet();
					default: ;
				endcase
				n_words = $urandom_range(20, 1);
				roll = $urandom_range(99, 0);
				if (roll < 70)
					queue_graph(n_words, 10, 1'b0);
				else if (roll < 85)
					queue_graph(n_words, 10, 1'b1);
				else
					queue_graph(n_words, 60, 1'b0);
				graph_words += n_words;
			end
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && node_results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
